[sv/ptob_pkg.sv]
// Shared constants and types for the price-time order book.
// Used by ptob_ctrl, ptob_dp and price_time_order_book; depends on nothing.
package ptob_pkg;

   localparam int MAX_ORDERS_DEF = 256;
   localparam int ID_W           = 32;
   localparam int QTY_W          = 32;
   localparam int PRICE_W        = 10;
   localparam int STATUS_W       = 2;

   // Request modes
   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // Sides
   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DUP       = 2'd3;

   // Order fields held per slot
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } ord_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture request fields
      logic clear;       // clear in-use flag at the sweep address
      logic scan1;       // lookup scan read at the sweep address
      logic scan2;       // best-price scan read at the sweep address
      logic report_clr;  // latch status, clear the top-of-book registers
      logic write1;      // place or unlink the order
      logic write2;      // link the old tail to the new order
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic do_write;
      logic need_w2;
   } sts_type;

endpackage

[sv/ptob_ctrl.sv]
// Controller state machine for the price-time order book.
// Depends on ptob_pkg; drives ptob_dp through command and status structs.
module ptob_ctrl #(
   parameter int MAX_ORDERS = ptob_pkg::MAX_ORDERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   output logic                          rsp_valid,
   output ptob_pkg::cmd_type             cmd,
   output logic [$clog2(MAX_ORDERS)-1:0] addr,
   input  ptob_pkg::sts_type             sts
);

   localparam int SW = $clog2(MAX_ORDERS);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SCAN1  = 4'd2;
   localparam logic [3:0] S_DRAIN1 = 4'd3;
   localparam logic [3:0] S_DECIDE = 4'd4;
   localparam logic [3:0] S_WRITE1 = 4'd5;
   localparam logic [3:0] S_WRITE2 = 4'd6;
   localparam logic [3:0] S_SCAN2  = 4'd7;
   localparam logic [3:0] S_DRAIN2 = 4'd8;
   localparam logic [3:0] S_RESP   = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          last;

   assign last      = (cnt_ff == SW'(MAX_ORDERS - 1));
   assign addr      = cnt_ff;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // Clear pass after reset, then per transaction: lookup scan, update, best-price scan, result
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN1;
            end
         end
         S_SCAN1: begin
            cmd.scan1 = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = S_DRAIN1;
            end
         end
         S_DRAIN1: state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.report_clr = 1'b1;
            state_in = sts.do_write ? S_WRITE1 : S_SCAN2;
         end
         S_WRITE1: begin
            cmd.write1 = 1'b1;
            state_in   = sts.need_w2 ? S_WRITE2 : S_SCAN2;
         end
         S_WRITE2: begin
            cmd.write2 = 1'b1;
            state_in   = S_SCAN2;
         end
         S_SCAN2: begin
            cmd.scan2 = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = S_DRAIN2;
            end
         end
         S_DRAIN2: state_in = S_RESP;
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Hold state and sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[sv/ptob_dp.sv]
// Datapath for the price-time order book: slot memories, scans, top of book.
// Depends on ptob_pkg; controlled by ptob_ctrl.
module ptob_dp #(
   parameter int MAX_ORDERS = ptob_pkg::MAX_ORDERS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptob_pkg::cmd_type                    cmd,
   input  logic [$clog2(MAX_ORDERS)-1:0]        addr,
   output ptob_pkg::sts_type                    sts,
   input  logic                                 req_mode,
   input  logic [ptob_pkg::ID_W-1:0]            req_order_id,
   input  logic                                 req_side,
   input  logic [ptob_pkg::PRICE_W-1:0]         req_price_tick,
   input  logic [ptob_pkg::QTY_W-1:0]           req_quantity,
   output logic [ptob_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_bid_valid,
   output logic [ptob_pkg::PRICE_W-1:0]         rsp_bid_price,
   output logic [ptob_pkg::ID_W-1:0]            rsp_bid_order_id,
   output logic [ptob_pkg::QTY_W-1:0]           rsp_bid_quantity,
   output logic                                 rsp_ask_valid,
   output logic [ptob_pkg::PRICE_W-1:0]         rsp_ask_price,
   output logic [ptob_pkg::ID_W-1:0]            rsp_ask_order_id,
   output logic [ptob_pkg::QTY_W-1:0]           rsp_ask_quantity
);

   localparam int SW = $clog2(MAX_ORDERS);

   // Slot store: in-use, order fields, FIFO links, head and tail marks
   logic              use_mem [MAX_ORDERS];
   ptob_pkg::ord_type ord_mem [MAX_ORDERS];
   logic [SW-1:0]     nxt_mem [MAX_ORDERS];
   logic [SW-1:0]     prv_mem [MAX_ORDERS];
   logic              hd_mem  [MAX_ORDERS];
   logic              tl_mem  [MAX_ORDERS];

   logic              use_rd_ff, hd_rd_ff, tl_rd_ff;
   ptob_pkg::ord_type ord_rd_ff;
   logic [SW-1:0]     nxt_rd_ff, prv_rd_ff, idx_ff;
   logic              s1_ff, s2_ff;

   // Captured request
   logic                         mode_ff, side_ff;
   logic [ptob_pkg::ID_W-1:0]    id_ff;
   logic [ptob_pkg::PRICE_W-1:0] price_ff;
   logic [ptob_pkg::QTY_W-1:0]   qty_ff;

   // Lookup results
   logic          found_ff, u_hd_ff, u_tl_ff, free_ff, tf_ff;
   logic [SW-1:0] u_ff, u_nx_ff, u_pv_ff, fs_ff, t_ff;
   logic          u_alone, rem_w, add_w;
   logic [ptob_pkg::STATUS_W-1:0] status_c;

   assign u_alone = u_hd_ff & u_tl_ff;
   assign add_w   = cmd.write1 & (mode_ff == ptob_pkg::MODE_ADD);
   assign rem_w   = cmd.write1 & (mode_ff == ptob_pkg::MODE_REMOVE);

   assign sts.do_write = (mode_ff == ptob_pkg::MODE_REMOVE) ? found_ff
                                                            : (~found_ff & free_ff);
   assign sts.need_w2  = (mode_ff == ptob_pkg::MODE_ADD) & tf_ff;

   always_comb begin
      if (mode_ff == ptob_pkg::MODE_REMOVE) begin
         status_c = found_ff ? ptob_pkg::ST_OK : ptob_pkg::ST_NOT_FOUND;
      end else if (found_ff) begin
         status_c = ptob_pkg::ST_DUP;
      end else if (!free_ff) begin
         status_c = ptob_pkg::ST_FULL;
      end else begin
         status_c = ptob_pkg::ST_OK;
      end
   end

   // Read every store at the sweep address
   always_ff @(posedge clock) begin
      use_rd_ff <= use_mem[addr];
      ord_rd_ff <= ord_mem[addr];
      nxt_rd_ff <= nxt_mem[addr];
      prv_rd_ff <= prv_mem[addr];
      hd_rd_ff  <= hd_mem[addr];
      tl_rd_ff  <= tl_mem[addr];
      idx_ff    <= addr;
   end

   // Delay scan flags to line up with the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.scan1;
         s2_ff <= cmd.scan2;
      end
   end

   // In-use flags: clear on sweep, set on add, drop on remove
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         use_mem[addr] <= 1'b0;
      end else if (add_w) begin
         use_mem[fs_ff] <= 1'b1;
      end else if (rem_w) begin
         use_mem[u_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (add_w) begin
         ord_mem[fs_ff] <= '{id: id_ff, side: side_ff, price: price_ff, qty: qty_ff};
      end
   end

   // Head marks: new order heads an empty level; next order takes over a head
   always_ff @(posedge clock) begin
      if (add_w) begin
         hd_mem[fs_ff] <= ~tf_ff;
      end else if (rem_w && !u_alone && u_hd_ff) begin
         hd_mem[u_nx_ff] <= 1'b1;
      end
   end

   // Tail marks
   always_ff @(posedge clock) begin
      if (add_w) begin
         tl_mem[fs_ff] <= 1'b1;
      end else if (rem_w && !u_alone && u_tl_ff) begin
         tl_mem[u_pv_ff] <= 1'b1;
      end else if (cmd.write2) begin
         tl_mem[t_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (add_w) begin
         prv_mem[fs_ff] <= t_ff;
      end else if (rem_w && !u_alone && !u_tl_ff) begin
         prv_mem[u_nx_ff] <= u_pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rem_w && !u_alone && !u_hd_ff) begin
         nxt_mem[u_pv_ff] <= u_nx_ff;
      end else if (cmd.write2) begin
         nxt_mem[t_ff] <= fs_ff;
      end
   end

   // Capture request and run the lookup scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         id_ff    <= req_order_id;
         side_ff  <= req_side;
         price_ff <= req_price_tick;
         qty_ff   <= req_quantity;
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
         tf_ff    <= 1'b0;
      end else if (s1_ff) begin
         if (use_rd_ff && ord_rd_ff.id == id_ff) begin
            found_ff <= 1'b1;
            u_ff     <= idx_ff;
            u_hd_ff  <= hd_rd_ff;
            u_tl_ff  <= tl_rd_ff;
            u_nx_ff  <= nxt_rd_ff;
            u_pv_ff  <= prv_rd_ff;
         end
         if (!use_rd_ff && !free_ff) begin
            free_ff <= 1'b1;
            fs_ff   <= idx_ff;
         end
         if (use_rd_ff && tl_rd_ff && ord_rd_ff.side == side_ff
             && ord_rd_ff.price == price_ff) begin
            tf_ff <= 1'b1;
            t_ff  <= idx_ff;
         end
      end
   end

   // Latch status and clear the top of book, then best-price scan over level heads
   always_ff @(posedge clock) begin
      if (cmd.report_clr) begin
         rsp_status       <= status_c;
         rsp_bid_valid    <= 1'b0;
         rsp_bid_price    <= '0;
         rsp_bid_order_id <= '0;
         rsp_bid_quantity <= '0;
         rsp_ask_valid    <= 1'b0;
         rsp_ask_price    <= '0;
         rsp_ask_order_id <= '0;
         rsp_ask_quantity <= '0;
      end else if (s2_ff && use_rd_ff && hd_rd_ff) begin
         if (ord_rd_ff.side == ptob_pkg::SIDE_BID) begin
            if (!rsp_bid_valid || ord_rd_ff.price > rsp_bid_price) begin
               rsp_bid_valid    <= 1'b1;
               rsp_bid_price    <= ord_rd_ff.price;
               rsp_bid_order_id <= ord_rd_ff.id;
               rsp_bid_quantity <= ord_rd_ff.qty;
            end
         end else begin
            if (!rsp_ask_valid || ord_rd_ff.price < rsp_ask_price) begin
               rsp_ask_valid    <= 1'b1;
               rsp_ask_price    <= ord_rd_ff.price;
               rsp_ask_order_id <= ord_rd_ff.id;
               rsp_ask_quantity <= ord_rd_ff.qty;
            end
         end
      end
   end

endmodule

[sv/price_time_order_book.sv]
// Top level of the price-time order book: controller plus datapath.
// Depends on ptob_pkg, ptob_ctrl and ptob_dp.
//
// A request (add or remove) is accepted at a clock edge with start high and busy
// low. Its result shows for one cycle with rsp_valid, which the receiver cannot
// stall. Two sweeps of the slot store run between the accepting edge and the
// result, each at one slot per cycle. The first looks up the id, the free slot
// and the level tail. The second finds the best bid and ask among the level
// heads. A drain state follows each sweep; a decide state follows the first
// drain, and a result state follows the second. A rejected add or an unknown id
// writes nothing. A remove, or an add to an empty level, writes only in the
// first write state; an add behind a resting order also needs the second. busy
// stays high up to and including the result cycle, so the next request can be
// accepted in the cycle after it. After reset, a clearing pass over every slot
// runs with busy high before the first request.
module price_time_order_book #(
   parameter int MAX_ORDERS = ptob_pkg::MAX_ORDERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [ptob_pkg::ID_W-1:0]     req_order_id,
   input  logic                          req_side,
   input  logic [ptob_pkg::PRICE_W-1:0]  req_price_tick,
   input  logic [ptob_pkg::QTY_W-1:0]    req_quantity,
   output logic                          rsp_valid,
   output logic [ptob_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_bid_valid,
   output logic [ptob_pkg::PRICE_W-1:0]  rsp_bid_price,
   output logic [ptob_pkg::ID_W-1:0]     rsp_bid_order_id,
   output logic [ptob_pkg::QTY_W-1:0]    rsp_bid_quantity,
   output logic                          rsp_ask_valid,
   output logic [ptob_pkg::PRICE_W-1:0]  rsp_ask_price,
   output logic [ptob_pkg::ID_W-1:0]     rsp_ask_order_id,
   output logic [ptob_pkg::QTY_W-1:0]    rsp_ask_quantity
);

   ptob_pkg::cmd_type               cmd;
   ptob_pkg::sts_type               sts;
   logic [$clog2(MAX_ORDERS)-1:0]   addr;

   ptob_ctrl #(.MAX_ORDERS(MAX_ORDERS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .addr      (addr),
      .sts       (sts)
   );

   ptob_dp #(.MAX_ORDERS(MAX_ORDERS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .addr             (addr),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_order_id     (req_order_id),
      .req_side         (req_side),
      .req_price_tick   (req_price_tick),
      .req_quantity     (req_quantity),
      .rsp_status       (rsp_status),
      .rsp_bid_valid    (rsp_bid_valid),
      .rsp_bid_price    (rsp_bid_price),
      .rsp_bid_order_id (rsp_bid_order_id),
      .rsp_bid_quantity (rsp_bid_quantity),
      .rsp_ask_valid    (rsp_ask_valid),
      .rsp_ask_price    (rsp_ask_price),
      .rsp_ask_order_id (rsp_ask_order_id),
      .rsp_ask_quantity (rsp_ask_quantity)
   );

endmodule
